/* hw/rtl/rpn_stack_evaluator_defines.svh */
// ---------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shared concurrent assertion forms for the evaluator RTL.
// ---------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rse_pkg.sv */
// ---------------------------------------------------------------------------
// RPN stack evaluator package
// Sizes, token and status codes, FSM states and the control/status bundles.
// ---------------------------------------------------------------------------
package rse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_OPER = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } oper_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIV_ZERO  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_RUN,
        S_WRITEBACK,
        S_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    push;
        logic    set_err;
        status_t err_code;
        logic    res_load;
        oper_t   op;
        logic    div_start;
        logic    writeback;
        logic    end_take;
        logic    emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic err_pending;
        logic lt_two;
        logic full;
        logic tos_zero;
        logic out_free;
        logic div_done;
    } stat_t;

endpackage

/* hw/rtl/rse_divider.sv */
// ---------------------------------------------------------------------------
// RPN stack evaluator divider
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ---------------------------------------------------------------------------
module rse_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [rse_pkg::DATA_W-1:0] dividend,
    input  logic signed [rse_pkg::DATA_W-1:0] divisor,
    output logic                              done,
    output logic signed [rse_pkg::DATA_W-1:0] quotient
);

    localparam int W = rse_pkg::DATA_W;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [rse_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                    rem_reg;
    logic [W-1:0]                    quo_reg;
    logic [W-1:0]                    dsr_reg;
    logic                            neg_reg;
    logic [W:0]                      trial;
    logic [W-1:0]                    dvd_mag;
    logic [W-1:0]                    dsr_mag;

    assign dvd_mag = dividend[W-1] ? (W'(0) - dividend) : dividend;
    assign dsr_mag = divisor[W-1]  ? (W'(0) - divisor)  : divisor;
    assign trial   = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = rse_pkg::DIV_CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - rse_pkg::DIV_CNT_W'(1);
            if (cnt_reg == rse_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift in one dividend bit, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dvd_mag;
            dsr_reg <= dsr_mag;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

/* hw/rtl/rse_datapath.sv */
// ---------------------------------------------------------------------------
// RPN stack evaluator datapath
// Operand stack memory, top-of-stack cache, ALU, divider and result register.
// ---------------------------------------------------------------------------
`include "rpn_stack_evaluator_defines.svh"

module rse_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rse_pkg::cmd_t                     cmd,
    output rse_pkg::stat_t                    stat,
    input  logic signed [rse_pkg::DATA_W-1:0] number,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rse_pkg::DATA_W-1:0] out_value,
    output rse_pkg::status_t                  out_status
);

    localparam int W     = rse_pkg::DATA_W;
    localparam int CNT_W = rse_pkg::CNT_W;
    localparam int IDX_W = rse_pkg::IDX_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(rse_pkg::STACK_DEPTH);

    logic [W-1:0]       stack_mem [rse_pkg::STACK_DEPTH];
    logic [W-1:0]       rd_data_reg;
    logic [W-1:0]       tos_reg;
    logic [W-1:0]       res_reg;
    logic [W-1:0]       pend_value_reg;
    rse_pkg::status_t   pend_status_reg;
    logic [W-1:0]       out_value_reg;
    rse_pkg::status_t   out_status_reg;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    rse_pkg::status_t   err_reg, err_next;

    logic [CNT_W-1:0]   count_m2;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [W-1:0]       wr_data;
    logic [W-1:0]       alu_res;
    logic               div_done;
    logic [W-1:0]       div_quot;
    rse_pkg::status_t   end_status;

    assign count_m2 = count_reg - CNT_W'(2);
    assign rd_addr  = count_m2[IDX_W-1:0];

    // Second operand sits in the top-of-stack cache, first one comes from memory
    rse_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        unique case (cmd.op)
            rse_pkg::OP_ADD: alu_res = rd_data_reg + tos_reg;
            rse_pkg::OP_SUB: alu_res = rd_data_reg - tos_reg;
            rse_pkg::OP_MUL: alu_res = rd_data_reg * tos_reg;
            rse_pkg::OP_DIV: alu_res = div_quot;
            default:         alu_res = rd_data_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.push | cmd.writeback;
        wr_addr = cmd.push ? count_reg[IDX_W-1:0] : count_m2[IDX_W-1:0];
        wr_data = cmd.push ? number : res_reg;
    end

    always_comb
    begin
        if (err_reg != rse_pkg::ST_OK)
            end_status = err_reg;
        else if (count_reg == '0)
            end_status = rse_pkg::ST_UNDERFLOW;
        else
            end_status = rse_pkg::ST_OK;
    end

    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.end_take)
        begin
            count_next = '0;
            err_next   = rse_pkg::ST_OK;
        end
        else if (cmd.set_err)
            err_next = cmd.err_code;
        else if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.writeback)
            count_next = count_reg - CNT_W'(1);

        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= rse_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= wr_data;
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
            tos_reg <= number;
        else if (cmd.writeback)
            tos_reg <= res_reg;

        if (cmd.res_load)
            res_reg <= alu_res;

        if (cmd.end_take)
        begin
            pend_status_reg <= end_status;
            pend_value_reg  <= (end_status == rse_pkg::ST_OK) ? tos_reg : '0;
        end

        if (cmd.emit)
        begin
            out_value_reg  <= pend_value_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign stat.err_pending = (err_reg != rse_pkg::ST_OK);
    assign stat.lt_two      = (count_reg < CNT_W'(2));
    assign stat.full        = (count_reg >= DEPTH_CNT);
    assign stat.tos_zero    = (tos_reg == '0);
    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.div_done    = div_done;

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    `RSE_ASSERT_IMP(a_push_not_full, clk, rst_n, cmd.push, count_reg < DEPTH_CNT, "push on full stack")
    `RSE_ASSERT_NXT(a_end_clears, clk, rst_n, cmd.end_take, count_reg == '0 && err_reg == rse_pkg::ST_OK, "end did not clear stack")
    `RSE_ASSERT_NXT(a_wb_pops, clk, rst_n, cmd.writeback, count_reg == $past(count_reg) - CNT_W'(1), "writeback count slip")

endmodule

/* hw/rtl/rse_ctrl.sv */
// ---------------------------------------------------------------------------
// RPN stack evaluator controller
// Token decode and sequencing of operator execution and result hand-off.
// ---------------------------------------------------------------------------
module rse_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rse_pkg::kind_t    kind,
    input  rse_pkg::oper_t    operation,
    output rse_pkg::cmd_t     cmd,
    input  rse_pkg::stat_t    stat
);

    rse_pkg::state_t state_reg, state_next;
    rse_pkg::oper_t  op_reg, op_next;
    logic            take;
    logic            oper_ok;

    assign take    = (state_reg == rse_pkg::S_IDLE) && in_valid;
    assign oper_ok = !stat.err_pending && !stat.lt_two &&
                     !(operation == rse_pkg::OP_DIV && stat.tos_zero);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            rse_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == rse_pkg::KIND_OPER && oper_ok)
                    begin
                        state_next = rse_pkg::S_EXEC;
                        op_next    = operation;
                    end
                    else if (kind == rse_pkg::KIND_END)
                        state_next = rse_pkg::S_EMIT;
                end
            end
            rse_pkg::S_EXEC:
                state_next = (op_reg == rse_pkg::OP_DIV) ? rse_pkg::S_DIV_RUN
                                                        : rse_pkg::S_WRITEBACK;
            rse_pkg::S_DIV_RUN:
                if (stat.div_done)
                    state_next = rse_pkg::S_WRITEBACK;
            rse_pkg::S_WRITEBACK:
                state_next = rse_pkg::S_IDLE;
            rse_pkg::S_EMIT:
                if (stat.out_free)
                    state_next = rse_pkg::S_IDLE;
            default:
                state_next = rse_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.op       = op_reg;
        cmd.err_code = rse_pkg::ST_OK;
        in_ready     = (state_reg == rse_pkg::S_IDLE);
        unique case (state_reg)
            rse_pkg::S_IDLE:
            begin
                if (take)
                begin
                    unique case (kind)
                        rse_pkg::KIND_PUSH:
                        begin
                            if (!stat.err_pending)
                            begin
                                if (stat.full)
                                begin
                                    cmd.set_err  = 1'b1;
                                    cmd.err_code = rse_pkg::ST_OVERFLOW;
                                end
                                else
                                    cmd.push = 1'b1;
                            end
                        end
                        rse_pkg::KIND_OPER:
                        begin
                            if (!stat.err_pending)
                            begin
                                if (stat.lt_two)
                                begin
                                    cmd.set_err  = 1'b1;
                                    cmd.err_code = rse_pkg::ST_UNDERFLOW;
                                end
                                else if (operation == rse_pkg::OP_DIV && stat.tos_zero)
                                begin
                                    cmd.set_err  = 1'b1;
                                    cmd.err_code = rse_pkg::ST_DIV_ZERO;
                                end
                            end
                        end
                        rse_pkg::KIND_END:
                            cmd.end_take = 1'b1;
                        default:
                            cmd.end_take = 1'b0;
                    endcase
                end
            end
            rse_pkg::S_EXEC:
            begin
                if (op_reg == rse_pkg::OP_DIV)
                    cmd.div_start = 1'b1;
                else
                    cmd.res_load = 1'b1;
            end
            rse_pkg::S_DIV_RUN:
                cmd.res_load = stat.div_done;
            rse_pkg::S_WRITEBACK:
                cmd.writeback = 1'b1;
            rse_pkg::S_EMIT:
                cmd.emit = stat.out_free;
            default:
                cmd.emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rse_pkg::S_IDLE;
            op_reg    <= rse_pkg::OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

/* hw/rtl/rpn_stack_evaluator.sv */
// ---------------------------------------------------------------------------
// RPN stack evaluator
// Reverse Polish integer evaluator over a bounded 32-bit operand stack.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Payload                                  Transfer
// s_*       in   tdata: number; tuser: kind, operation    s_tvalid & s_tready
// m_*       out  tdata: value;  tuser: status             m_tvalid & m_tready
//
// Steps: push, ignored and error tokens finish in idle; add, subtract,
//   multiply: execute, writeback; divide: execute, the one-bit-per-cycle
//   divider run, writeback; end: emit, held until the output register frees.
// Reset: asynchronous, active low; the stack empties, no error pending.
// Stalls: an end token waits in the controller until the output register
//   frees; one result may wait on the master side while tokens flow on.
// ---------------------------------------------------------------------------
module rpn_stack_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] number
    input  logic [3:0]  s_tuser,   // [1:0] kind, [3:2] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic [1:0]  m_tuser    // [1:0] status
);

    rse_pkg::cmd_t    cmd;
    rse_pkg::stat_t   stat;
    rse_pkg::kind_t   kind;
    rse_pkg::oper_t   operation;
    rse_pkg::status_t status;
    logic signed [rse_pkg::DATA_W-1:0] number;
    logic signed [rse_pkg::DATA_W-1:0] value;

    // Unpack the token fields
    assign kind      = rse_pkg::kind_t'(s_tuser[1:0]);
    assign operation = rse_pkg::oper_t'(s_tuser[3:2]);
    assign number    = s_tdata;

    // Sequence tokens: decode, operator steps, result hand-off
    rse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (kind),
        .operation (operation),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold the stack, compute and register the result
    rse_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .number     (number),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (value),
        .out_status (status)
    );

    assign m_tdata = value;
    assign m_tuser = status;

endmodule
